/* rtl/core/swia_pkg.sv */
// ----------------------------------------------------------------------------
// swia_pkg
// shared codes, field widths and cell control type for the indexed stack
// ----------------------------------------------------------------------------
`default_nettype none

package swia_pkg;

    localparam int KIND_W   = 3;
    localparam int POS_W    = 5;
    localparam int STATUS_W = 2;

    // operation codes carried in the input tuser
    localparam logic [KIND_W-1:0] KIND_PUSH = 3'd0;
    localparam logic [KIND_W-1:0] KIND_POP  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_GET  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_SET  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_FIND = 3'd4;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

    // per-cell control from the stack control
    typedef struct packed {
        logic live;     // cell lies below the fill count
        logic wr_en;    // load the incoming word
        logic find_en;  // find-and-remove in progress
    } t_cell_ctl;

endpackage

`default_nettype wire

/* rtl/core/stack_with_indexed_access.sv */
// ----------------------------------------------------------------------------
// stack_with_indexed_access
// bounded lifo of data words with push, pop, indexed get and set, and
// removal of the topmost entry equal to a given nonzero word
// ----------------------------------------------------------------------------
//  channel  | dir | tdata (low bit up)                  | tuser
//  s_axis   | in  | value, position (signed), zero pad  | kind
//  m_axis   | out | result_value, depth_used, zero pad  | status
//
//  every operation completes in the cycle of its transaction; one result
//  per input transaction lands in a single output register
//  a new transaction is taken while the held result is being taken, so the
//  sustained rate is one transaction per cycle with no stall downstream
//  the search for find-and-remove ripples through the row of cells, one
//  bit per cell, top to bottom
//  synchronous active-low reset clears the fill count and the output valid;
//  the entries are not cleared and only slots below the fill count are read
// ----------------------------------------------------------------------------
`default_nettype none

module stack_with_indexed_access #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    // value, position
    input  wire                        s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire  [((DATA_WIDTH+swia_pkg::POS_W+7)/8)*8-1:0] s_axis_tdata,
    // kind
    input  wire  [swia_pkg::KIND_W-1:0] s_axis_tuser,
    // result_value, depth_used
    output logic                       m_axis_tvalid,
    input  wire                        m_axis_tready,
    output logic [((DATA_WIDTH+$clog2(DEPTH+1)+7)/8)*8-1:0] m_axis_tdata,
    // status
    output logic [swia_pkg::STATUS_W-1:0] m_axis_tuser
);
    import swia_pkg::*;

    localparam int CW      = $clog2(DEPTH + 1);
    localparam int AW      = $clog2(DEPTH);
    localparam int CMP_W   = (CW > POS_W) ? CW + 1 : POS_W + 1;
    localparam int OUT_W   = ((DATA_WIDTH + CW + 7) / 8) * 8;
    localparam int OUT_PAD = OUT_W - DATA_WIDTH - CW;

    // input transaction fields
    logic                  in_acc;
    logic [KIND_W-1:0]     in_kind;
    logic [DATA_WIDTH-1:0] in_value;
    logic [POS_W-1:0]      in_pos;

    // stack state and output register
    logic [CW-1:0]         r_fill;
    logic [CW-1:0]         n_fill;
    logic                  r_out_valid;
    logic [DATA_WIDTH-1:0] r_out_value;
    logic [DATA_WIDTH-1:0] n_out_value;
    logic [STATUS_W-1:0]   r_out_status;
    logic [STATUS_W-1:0]   n_out_status;
    logic [CW-1:0]         r_out_depth;

    // position decode
    logic [CMP_W-1:0]      fill_ext;
    logic [CMP_W-1:0]      pos_ext;
    logic [CMP_W-1:0]      neg_ext;
    logic [CMP_W-1:0]      slot_ext;
    logic                  loc_ok;
    logic [AW-1:0]         loc_slot;

    // cell row
    logic [DATA_WIDTH-1:0] w_words [DEPTH];
    logic [DEPTH-1:0]      w_hit;
    logic [DEPTH:0]        w_found;
    logic                  wr_any;
    logic [AW-1:0]         wr_slot;
    logic [AW-1:0]         rd_slot;
    logic [DATA_WIDTH-1:0] rd_word;
    logic                  find_en;
    logic                  full;
    logic                  empty;

    assign in_kind  = s_axis_tuser;
    assign in_value = s_axis_tdata[DATA_WIDTH-1:0];
    assign in_pos   = s_axis_tdata[DATA_WIDTH +: POS_W];

    // the output register frees up in the same cycle it is taken
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    assign full  = (r_fill == CW'(DEPTH));
    assign empty = (r_fill == '0);

    // non-negative positions count down from the top, negative ones count
    // up from the bottom with the bottom at minus one
    always_comb begin
        fill_ext = CMP_W'(r_fill);
        pos_ext  = CMP_W'(in_pos);
        neg_ext  = CMP_W'(1 << POS_W) - pos_ext;
        if (!in_pos[POS_W-1]) begin
            loc_ok   = pos_ext < fill_ext;
            slot_ext = fill_ext - CMP_W'(1) - pos_ext;
        end else begin
            loc_ok   = neg_ext <= fill_ext;
            slot_ext = neg_ext - CMP_W'(1);
        end
        loc_slot = slot_ext[AW-1:0];
    end

    assign find_en = in_acc && (in_kind == KIND_FIND);

    // one write port into the row: push at the fill count, set at the slot
    always_comb begin
        wr_any  = 1'b0;
        wr_slot = loc_slot;
        if (in_acc && (in_kind == KIND_PUSH) && !full) begin
            wr_any  = 1'b1;
            wr_slot = r_fill[AW-1:0];
        end else if (in_acc && (in_kind == KIND_SET) && loc_ok) begin
            wr_any  = 1'b1;
        end
    end

    // one read port: pop reads the top, get reads the decoded slot
    assign rd_slot = (in_kind == KIND_POP) ? AW'(r_fill - CW'(1)) : loc_slot;
    assign rd_word = w_words[rd_slot];

    // search chain enters at the top cell and leaves at the bottom
    assign w_found[DEPTH] = 1'b0;

    for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
        t_cell_ctl             ctl;
        logic [DATA_WIDTH-1:0] upper;

        assign ctl.live    = CW'(gi) < r_fill;
        assign ctl.wr_en   = wr_any && (wr_slot == AW'(gi));
        assign ctl.find_en = find_en;

        if (gi == DEPTH - 1) begin : g_top
            assign upper = '0;
        end else begin : g_mid
            assign upper = w_words[gi+1];
        end

        swia_cell #(
            .DATA_WIDTH (DATA_WIDTH)
        ) u_cell (
            .i_clk         (i_clk),
            .i_ctl         (ctl),
            .i_wr_data     (in_value),
            .i_upper_word  (upper),
            .i_found_above (w_found[gi+1]),
            .i_any_found   (w_found[0]),
            .o_word        (w_words[gi]),
            .o_hit         (w_hit[gi]),
            .o_found       (w_found[gi])
        );
    end

    // result and new fill count
    always_comb begin
        n_fill       = r_fill;
        n_out_value  = '0;
        n_out_status = ST_OK;
        unique case (in_kind)
            KIND_PUSH: begin
                if (full) begin
                    n_out_status = ST_FULL;
                end else begin
                    n_fill      = r_fill + CW'(1);
                    n_out_value = in_value;
                end
            end
            KIND_POP: begin
                if (empty) begin
                    n_out_status = ST_MISS;
                end else begin
                    n_fill      = r_fill - CW'(1);
                    n_out_value = rd_word;
                end
            end
            KIND_GET: begin
                if (loc_ok) begin
                    n_out_value = rd_word;
                end else begin
                    n_out_status = ST_MISS;
                end
            end
            KIND_SET: begin
                if (!loc_ok) begin
                    n_out_status = ST_MISS;
                end
            end
            KIND_FIND: begin
                if (w_found[0]) begin
                    n_fill      = r_fill - CW'(1);
                    n_out_value = in_value;
                end else begin
                    n_out_status = ST_MISS;
                end
            end
            default: begin
                // meaningless kinds leave the stack alone and report ok
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                r_fill      <= n_fill;
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_out_value  <= n_out_value;
            r_out_status <= n_out_status;
            r_out_depth  <= n_fill;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_status;
    if (OUT_PAD > 0) begin : g_pad
        assign m_axis_tdata = {{OUT_PAD{1'b0}}, r_out_depth, r_out_value};
    end else begin : g_nopad
        assign m_axis_tdata = {r_out_depth, r_out_value};
    end

    // fill count never passes the capacity
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CW'(DEPTH))
        else $error("fill count beyond capacity");

    // the search chain removes at most one entry
    a_one_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_hit))
        else $error("more than one cell removed");

    // a held result always reports the current fill count
    a_depth_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_depth == r_fill))
        else $error("reported depth out of step with fill count");

    // a push into a full stack is reported and changes nothing
    a_full_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (in_kind == KIND_PUSH) && full)
        |=> ((r_out_status == ST_FULL) && (r_fill == CW'(DEPTH))))
        else $error("push into full stack not dropped");

endmodule

`default_nettype wire

/* rtl/core/swia_cell.sv */
// ----------------------------------------------------------------------------
// swia_cell
// one stack entry: holds a word, matches it against the search word and
// takes its upper neighbour's word when an entry at or below it is removed
// ----------------------------------------------------------------------------
`default_nettype none

module swia_cell #(
    parameter int DATA_WIDTH = 32
) (
    input  wire                        i_clk,
    input  wire swia_pkg::t_cell_ctl   i_ctl,
    input  wire  [DATA_WIDTH-1:0]      i_wr_data,
    input  wire  [DATA_WIDTH-1:0]      i_upper_word,
    input  wire                        i_found_above,
    input  wire                        i_any_found,
    output logic [DATA_WIDTH-1:0]      o_word,
    output logic                       o_hit,
    output logic                       o_found
);
    import swia_pkg::*;

    logic [DATA_WIDTH-1:0] r_word;
    logic [DATA_WIDTH-1:0] n_word;

    // topmost live nonzero match wins, the chain blocks every cell below it
    assign o_hit   = i_ctl.live && (r_word != '0) && (r_word == i_wr_data)
                     && !i_found_above;
    assign o_found = i_found_above || o_hit;
    assign o_word  = r_word;

    // the removed cell and every cell above it close the gap
    always_comb begin
        n_word = r_word;
        if (i_ctl.find_en && i_any_found && !i_found_above) begin
            n_word = i_upper_word;
        end else if (i_ctl.wr_en) begin
            n_word = i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

endmodule

`default_nettype wire
